@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned PRIO_WIDTH   = 16;
  localparam int unsigned HANDLE_WIDTH = 16;

  // Request kinds carried in the input tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } cmd_t;

endpackage

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell #(
  parameter int unsigned KEY_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::cmd_t                        cmd,
  input  logic [KEY_WIDTH-1:0]                 new_key,
  input  logic [spq_pkg::HANDLE_WIDTH-1:0]     new_handle,
  input  logic                                 prev_valid,
  input  logic [KEY_WIDTH-1:0]                 prev_key,
  input  logic [spq_pkg::HANDLE_WIDTH-1:0]     prev_handle,
  input  logic                                 prev_shift,
  input  logic                                 next_valid,
  input  logic [KEY_WIDTH-1:0]                 next_key,
  input  logic [spq_pkg::HANDLE_WIDTH-1:0]     next_handle,
  output logic                                 valid,
  output logic [KEY_WIDTH-1:0]                 key,
  output logic [spq_pkg::HANDLE_WIDTH-1:0]     handle,
  output logic                                 shift
);

  logic                             valid_next;
  logic [KEY_WIDTH-1:0]             key_next;
  logic [spq_pkg::HANDLE_WIDTH-1:0] handle_next;

  // An empty cell or one with a larger key makes room for the new entry;
  // equal keys stay put so ties keep arrival order
  assign shift = !valid || (key > new_key);

  // Select the next contents of this cell
  always_comb begin
    valid_next  = valid;
    key_next    = key;
    handle_next = handle;
    if (cmd.ins && shift) begin
      if (prev_shift) begin
        valid_next  = prev_valid;
        key_next    = prev_key;
        handle_next = prev_handle;
      end else begin
        valid_next  = 1'b1;
        key_next    = new_key;
        handle_next = new_handle;
      end
    end else if (cmd.pop) begin
      valid_next  = next_valid;
      key_next    = next_key;
      handle_next = next_handle;
    end
  end

  // Clear the valid flag under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    key    <= key_next;
    handle <= handle_next;
  end

endmodule

@@ design/stable_priority_queue_core.sv @@
`timescale 1ns / 1ps

// Stable sorted priority queue.
// Input stream (s_axis_*): one request per item. tuser selects insert or pop,
// tdata carries the priority key and the handle of an entry to insert.
// Output stream (m_axis_*): exactly one result item per request, in request
// order. tuser gives the status (inserted, popped, underflow, dropped full),
// tdata the popped key and handle, zero for any other status.
// Entries live in a row of QUEUE_DEPTH cells kept sorted by ascending key;
// every cell compares against the broadcast key in parallel. In the same
// cycle the cells from the insert point on shift one place right (insert),
// or all cells shift one place left (pop). Equal keys leave in arrival order.
// The result is registered in the cycle after the request is accepted.
// Throughput: one item per cycle while the receiver does not stall.
// Reset clears every cell's valid flag and the entry count; the queue is
// empty and ready on the first cycle after reset.
// When the receiver stalls, the result waits in the output register and the
// input stalls with it; no result is lost or repeated.

module stable_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] priority_req, [31:16] handle
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_priority, [31:16] out_handle
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HW    = spq_pkg::HANDLE_WIDTH;
  localparam int unsigned PW    = spq_pkg::PRIO_WIDTH;

  logic                 accept;
  logic                 is_pop;
  logic                 full;
  logic                 empty;
  logic [KEY_WIDTH-1:0] in_key;
  logic [HW-1:0]        in_handle;
  logic [PW-1:0]        front_prio;
  spq_pkg::cmd_t        cmd;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  logic                 out_valid;
  spq_pkg::status_t     out_status;
  logic [PW-1:0]        out_prio;
  logic [HW-1:0]        out_hnd;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_shift;
  logic [KEY_WIDTH-1:0]   cell_key    [QUEUE_DEPTH];
  logic [HW-1:0]          cell_handle [QUEUE_DEPTH];

  // Take a new item out of reset whenever the result register is free or being drained
  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_pop        = (s_axis_tuser == spq_pkg::REQ_POP);
  assign in_handle     = s_axis_tdata[31:16];
  assign full          = (count == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count == '0);

  // Fit the 16-bit request key to the stored key width and back
  generate
    if (KEY_WIDTH <= PW) begin : g_key_narrow
      assign in_key     = s_axis_tdata[KEY_WIDTH-1:0];
      assign front_prio = PW'(cell_key[0]);
    end else begin : g_key_wide
      assign in_key     = KEY_WIDTH'(s_axis_tdata[PW-1:0]);
      assign front_prio = cell_key[0][PW-1:0];
    end
  endgenerate

  // Broadcast command to the chain
  always_comb begin
    cmd.ins = accept && !is_pop && !full;
    cmd.pop = accept &&  is_pop && !empty;
  end

  // Row of sorted cells
  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 p_valid;
      logic [KEY_WIDTH-1:0] p_key;
      logic [HW-1:0]        p_handle;
      logic                 p_shift;
      logic                 n_valid;
      logic [KEY_WIDTH-1:0] n_key;
      logic [HW-1:0]        n_handle;

      if (i == 0) begin : g_first
        assign p_valid  = 1'b0;
        assign p_key    = '0;
        assign p_handle = '0;
        assign p_shift  = 1'b0;
      end else begin : g_mid
        assign p_valid  = cell_valid[i-1];
        assign p_key    = cell_key[i-1];
        assign p_handle = cell_handle[i-1];
        assign p_shift  = cell_shift[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign n_valid  = 1'b0;
        assign n_key    = '0;
        assign n_handle = '0;
      end else begin : g_inner
        assign n_valid  = cell_valid[i+1];
        assign n_key    = cell_key[i+1];
        assign n_handle = cell_handle[i+1];
      end

      spq_cell #(
        .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .new_key     (in_key),
        .new_handle  (in_handle),
        .prev_valid  (p_valid),
        .prev_key    (p_key),
        .prev_handle (p_handle),
        .prev_shift  (p_shift),
        .next_valid  (n_valid),
        .next_key    (n_key),
        .next_handle (n_handle),
        .valid       (cell_valid[i]),
        .key         (cell_key[i]),
        .handle      (cell_handle[i]),
        .shift       (cell_shift[i])
      );
    end
  endgenerate

  // Track the number of stored entries
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload for each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_prio <= '0;
      out_hnd  <= '0;
      if (is_pop) begin
        if (empty) begin
          out_status <= spq_pkg::ST_UNDERFLOW;
        end else begin
          out_status <= spq_pkg::ST_POPPED;
          out_prio   <= front_prio;
          out_hnd    <= cell_handle[0];
        end
      end else if (full) begin
        out_status <= spq_pkg::ST_FULL;
      end else begin
        out_status <= spq_pkg::ST_INSERTED;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_hnd, out_prio};
  assign m_axis_tuser  = out_status;

  // Entry count always matches the number of occupied cells
  assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("entry count differs from occupied cells");

  // Occupied cells form a contiguous run from the front
  assert property (@(posedge clk) disable iff (rst)
    (cell_valid[QUEUE_DEPTH-1:1] & ~cell_valid[QUEUE_DEPTH-2:0]) == '0)
    else $error("gap in occupied cells");

  // Any status other than popped carries a zero payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != spq_pkg::ST_POPPED) |-> m_axis_tdata == '0)
    else $error("nonzero payload on non-pop result");

  // A placed insert grows the queue by one
  assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue");

  // A pop from a nonempty queue shrinks it by one
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not shrink the queue");

endmodule
